/* design/acs_pkg.sv */
// Shared types, constants and helper functions of the ASCII command scoreboard.
package acs_pkg;

    localparam int LINE_LEN  = 64;
    localparam int POS_W     = $clog2(LINE_LEN);
    localparam int SEG_W     = 7;
    localparam int SCORE_W   = 7;
    localparam int DIGIT_W   = 4;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_BEEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_BEEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PER   = 2'd2;

    localparam logic [TICK_W-1:0] SHORT_BEEP_RST = 16'd160;
    localparam logic [TICK_W-1:0] LONG_BEEP_RST  = 16'd1000;
    localparam logic [TICK_W-1:0] HALF_PER_RST   = 16'd10;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_R     = 8'h52;

    localparam int SCORE_PREFIX_LEN = 10;
    localparam int OVER_PREFIX_LEN  = 14;
    localparam logic [7:0] MAX_SCORE = 8'd99;

    typedef enum logic [1:0] {
        NUM_SKIP   = 2'd0,
        NUM_SIGN   = 2'd1,
        NUM_DIGITS = 2'd2,
        NUM_DONE   = 2'd3
    } t_num_phase;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } t_digits;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] ticks;
    } t_beep_req;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic             tens_select;
        logic             units_select;
        logic             buzzer_out;
        logic             flap_led;
        logic             flap_event;
    } t_view;

    // "BUF:SCORE="
    function automatic logic [7:0] score_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h42;
            4'd1:    ch = 8'h55;
            4'd2:    ch = 8'h46;
            4'd3:    ch = 8'h3A;
            4'd4:    ch = 8'h53;
            4'd5:    ch = 8'h43;
            4'd6:    ch = 8'h4F;
            4'd7:    ch = 8'h52;
            4'd8:    ch = 8'h45;
            4'd9:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "BUF:GAMEOVER=1"
    function automatic logic [7:0] over_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h42;
            4'd1:    ch = 8'h55;
            4'd2:    ch = 8'h46;
            4'd3:    ch = 8'h3A;
            4'd4:    ch = 8'h47;
            4'd5:    ch = 8'h41;
            4'd6:    ch = 8'h4D;
            4'd7:    ch = 8'h45;
            4'd8:    ch = 8'h4F;
            4'd9:    ch = 8'h56;
            4'd10:   ch = 8'h45;
            4'd11:   ch = 8'h52;
            4'd12:   ch = 8'h3D;
            4'd13:   ch = 8'h31;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] seg;
        unique case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // split 0..99 into decimal digits; x*205>>11 equals x/10 over this range
    function automatic t_digits split_digits(input logic [6:0] v);
        logic [14:0] prod;
        t_digits     res;
        prod      = 15'(v) * 15'd205;
        res.tens  = prod[14:11];
        res.units = 4'(v - 7'({res.tens, 3'b000}) - 7'({res.tens, 1'b0}));
        return res;
    endfunction

    function automatic logic [SCORE_W-1:0] score_of(input t_digits d);
        return SCORE_W'({d.tens, 3'b000}) + SCORE_W'({d.tens, 1'b0}) + SCORE_W'(d.units);
    endfunction

endpackage

/* design/acs_in_if.sv */
// Input item channel: received byte or loop tick.
interface acs_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;
    logic       button_level;

    modport source(output valid, func, rx_byte, button_level, input ready);
    modport sink(input valid, func, rx_byte, button_level, output ready);
endinterface

/* design/acs_out_if.sv */
// Result item channel: display, buzzer, button and score levels.
interface acs_out_if import acs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SEG_W-1:0]   segments;
    logic               tens_select;
    logic               units_select;
    logic               buzzer_out;
    logic               flap_led;
    logic               flap_event;
    logic [SCORE_W-1:0] score_out;

    modport source(output valid, segments, tens_select, units_select, buzzer_out,
                   flap_led, flap_event, score_out, input ready);
    modport sink(input valid, segments, tens_select, units_select, buzzer_out,
                 flap_led, flap_event, score_out, output ready);
endinterface

/* design/acs_cfg_if.sv */
// Configuration write channel.
interface acs_cfg_if import acs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TICK_W-1:0]    data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* design/acs_line_parser.sv */
// Line assembler: prefix matching, number parsing and score digits.
module acs_line_parser import acs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_en,
    input  logic [7:0]        i_byte,
    input  logic [TICK_W-1:0] i_short_ticks,
    input  logic [TICK_W-1:0] i_long_ticks,
    output t_beep_req         o_beep,
    output t_digits           o_digits,
    output t_digits           o_n_digits
);

    logic [POS_W-1:0] r_pos,      n_pos;
    logic             r_score_m,  n_score_m;
    logic             r_over_m,   n_over_m;
    logic             r_reset_m,  n_reset_m;
    t_num_phase       r_phase,    n_phase;
    logic             r_neg,      n_neg;
    logic [7:0]       r_value,    n_value;
    t_digits          r_digits,   n_digits;

    logic       s_is_digit;
    logic       s_is_space;
    logic [7:0] s_signed_val;

    assign s_is_digit   = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign s_is_space   = (i_byte == CHAR_SPACE) || (i_byte == CHAR_TAB) ||
                          (i_byte == CHAR_VT) || (i_byte == CHAR_FF);
    assign s_signed_val = r_neg ? 8'(8'd0 - r_value) : r_value;

    always_comb begin
        n_pos     = r_pos;
        n_score_m = r_score_m;
        n_over_m  = r_over_m;
        n_reset_m = r_reset_m;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_value   = r_value;
        n_digits  = r_digits;
        o_beep    = '{start: 1'b0, ticks: i_short_ticks};

        if (i_byte_en) begin
            priority if (i_byte == CHAR_LF || i_byte == CHAR_CR) begin
                if (r_score_m && r_pos >= POS_W'(SCORE_PREFIX_LEN)) begin
                    // an out-of-range score is ignored and blocks the other commands
                    if (s_signed_val <= MAX_SCORE) begin
                        n_digits     = split_digits(s_signed_val[6:0]);
                        o_beep.start = 1'b1;
                    end
                end else if (r_over_m && r_pos >= POS_W'(OVER_PREFIX_LEN)) begin
                    o_beep.start = 1'b1;
                    o_beep.ticks = i_long_ticks;
                end else if (r_reset_m && r_pos == POS_W'(1)) begin
                    n_digits = '0;
                end
                n_pos = '0; n_score_m = 1'b1; n_over_m = 1'b1; n_reset_m = 1'b1;
                n_phase = NUM_SKIP; n_neg = 1'b0; n_value = '0;
            end else if (r_pos >= POS_W'(LINE_LEN - 1)) begin
                // overflow: drop the character and restart the line
                n_pos = '0; n_score_m = 1'b1; n_over_m = 1'b1; n_reset_m = 1'b1;
                n_phase = NUM_SKIP; n_neg = 1'b0; n_value = '0;
            end else begin
                if (r_pos < POS_W'(SCORE_PREFIX_LEN)) begin
                    if (score_char(r_pos[3:0]) != i_byte) n_score_m = 1'b0;
                end else if (r_score_m) begin
                    priority if (r_phase == NUM_SKIP && s_is_space) begin
                        n_phase = r_phase;
                    end else if (r_phase == NUM_SKIP &&
                                 (i_byte == CHAR_PLUS || i_byte == CHAR_MINUS)) begin
                        n_neg   = (i_byte == CHAR_MINUS);
                        n_phase = NUM_SIGN;
                    end else if (r_phase == NUM_DONE) begin
                        n_phase = r_phase;
                    end else if (s_is_digit) begin
                        n_value = 8'({r_value, 3'b000}) + 8'({r_value, 1'b0}) +
                                  8'(i_byte - CHAR_ZERO);
                        n_phase = NUM_DIGITS;
                    end else begin
                        n_phase = NUM_DONE;
                    end
                end
                if (r_pos < POS_W'(OVER_PREFIX_LEN) && over_char(r_pos[3:0]) != i_byte) begin
                    n_over_m = 1'b0;
                end
                if (r_pos != '0 || i_byte != CHAR_R) n_reset_m = 1'b0;
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_score_m <= 1'b1;
            r_over_m  <= 1'b1;
            r_reset_m <= 1'b1;
            r_phase   <= NUM_SKIP;
            r_neg     <= 1'b0;
            r_value   <= '0;
            r_digits  <= '0;
        end else begin
            r_pos     <= n_pos;
            r_score_m <= n_score_m;
            r_over_m  <= n_over_m;
            r_reset_m <= n_reset_m;
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_value   <= n_value;
            r_digits  <= n_digits;
        end
    end

    assign o_digits   = r_digits;
    assign o_n_digits = n_digits;

endmodule

/* design/acs_tick_unit.sv */
// Loop tick logic: button edges, digit multiplexing and buzzer tone.
module acs_tick_unit import acs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick_en,
    input  logic              i_button,
    input  t_digits           i_digits,
    input  t_beep_req         i_beep,
    input  logic [TICK_W-1:0] i_half_period,
    output t_view             o_view
);

    logic [TICK_W-1:0] r_beep_left, n_beep_left;
    logic [TICK_W-1:0] r_tone_cnt,  n_tone_cnt;
    logic              r_buzz,      n_buzz;
    logic              r_dphase,    n_dphase;
    logic              r_last_btn,  n_last_btn;
    logic              r_led,       n_led;
    logic [SEG_W-1:0]  r_seg,       n_seg;
    logic              r_tens_sel,  n_tens_sel;
    logic              r_units_sel, n_units_sel;
    logic              s_event;
    logic [TICK_W-1:0] s_tone_inc;

    assign s_tone_inc = r_tone_cnt + TICK_W'(1);

    always_comb begin
        n_beep_left = r_beep_left;
        n_tone_cnt  = r_tone_cnt;
        n_buzz      = r_buzz;
        n_dphase    = r_dphase;
        n_last_btn  = r_last_btn;
        n_led       = r_led;
        n_seg       = r_seg;
        n_tens_sel  = r_tens_sel;
        n_units_sel = r_units_sel;
        s_event     = 1'b0;

        if (i_beep.start) n_beep_left = i_beep.ticks;

        if (i_tick_en) begin
            s_event    = (i_button != r_last_btn);
            if (s_event) n_led = !i_button;
            n_last_btn = i_button;

            if (!r_dphase) begin
                n_tens_sel  = 1'b0;
                n_units_sel = 1'b1;
                n_seg       = seg_of(i_digits.tens);
            end else begin
                n_tens_sel  = 1'b1;
                n_units_sel = 1'b0;
                n_seg       = seg_of(i_digits.units);
            end
            n_dphase = !r_dphase;

            if (r_beep_left != '0) begin
                if (s_tone_inc >= i_half_period) begin
                    n_buzz     = !r_buzz;
                    n_tone_cnt = '0;
                end else begin
                    n_tone_cnt = s_tone_inc;
                end
                n_beep_left = r_beep_left - TICK_W'(1);
            end else begin
                n_buzz = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_left <= '0;
            r_tone_cnt  <= '0;
            r_buzz      <= 1'b0;
            r_dphase    <= 1'b0;
            r_last_btn  <= 1'b1;
            r_led       <= 1'b0;
            r_seg       <= '0;
            r_tens_sel  <= 1'b0;
            r_units_sel <= 1'b0;
        end else begin
            r_beep_left <= n_beep_left;
            r_tone_cnt  <= n_tone_cnt;
            r_buzz      <= n_buzz;
            r_dphase    <= n_dphase;
            r_last_btn  <= n_last_btn;
            r_led       <= n_led;
            r_seg       <= n_seg;
            r_tens_sel  <= n_tens_sel;
            r_units_sel <= n_units_sel;
        end
    end

    // levels as they stand after this item
    assign o_view = '{segments:     n_seg,
                      tens_select:  n_tens_sel,
                      units_select: n_units_sel,
                      buzzer_out:   n_buzz,
                      flap_led:     n_led,
                      flap_event:   s_event};

endmodule

/* design/ascii_command_scoreboard_top.sv */
// Top level of the ASCII command scoreboard: item registers, config bank, units.
//
// The block accepts one item, received byte or loop tick, per clock while the result
// register is not stalled: an item is captured in the input register, applied to the
// line matcher or the tick logic as it leaves that register, and its result is
// captured in the result register, from which it is offered. A stalled result does
// not stop the next item from entering the input register.
// Configuration writes are always ready.
module ascii_command_scoreboard_top import acs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acs_in_if.sink      i_in,
    acs_out_if.source   o_out,
    acs_cfg_if.sink     i_cfg
);

    logic               r_in_valid;
    logic               r_func;
    logic [7:0]         r_byte;
    logic               r_button;

    logic               r_out_valid;
    t_view              r_view;
    logic [SCORE_W-1:0] r_score;

    logic [TICK_W-1:0]  r_short_ticks;
    logic [TICK_W-1:0]  r_long_ticks;
    logic [TICK_W-1:0]  r_half_period;

    logic               s_step;
    t_beep_req          s_beep;
    t_digits            s_digits;
    t_digits            s_n_digits;
    t_view              s_view;

    assign s_step      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || s_step;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (s_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func   <= i_in.func;
            r_byte   <= i_in.rx_byte;
            r_button <= i_in.button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= SHORT_BEEP_RST;
            r_long_ticks  <= LONG_BEEP_RST;
            r_half_period <= HALF_PER_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SHORT_BEEP: r_short_ticks <= i_cfg.data;
                CFG_LONG_BEEP:  r_long_ticks  <= i_cfg.data;
                CFG_HALF_PER:   r_half_period <= i_cfg.data;
                default:        ;
            endcase
        end
    end

    acs_line_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_en     (s_step && !r_func),
        .i_byte        (r_byte),
        .i_short_ticks (r_short_ticks),
        .i_long_ticks  (r_long_ticks),
        .o_beep        (s_beep),
        .o_digits      (s_digits),
        .o_n_digits    (s_n_digits)
    );

    acs_tick_unit u_tick (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_en     (s_step && r_func),
        .i_button      (r_button),
        .i_digits      (s_digits),
        .i_beep        (s_beep),
        .i_half_period (r_half_period),
        .o_view        (s_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step) begin
            r_view  <= s_view;
            r_score <= score_of(s_n_digits);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.segments     = r_view.segments;
    assign o_out.tens_select  = r_view.tens_select;
    assign o_out.units_select = r_view.units_select;
    assign o_out.buzzer_out   = r_view.buzzer_out;
    assign o_out.flap_led     = r_view.flap_led;
    assign o_out.flap_event   = r_view.flap_event;
    assign o_out.score_out    = r_score;

endmodule
